FILE: rtl/spectrum_band_amplitude_averager_macros.svh
// ----------------------------------------------------------------------------
// spectrum band amplitude averager assertion macros
// shared assertion wrappers, clocked on clk with the synchronous rst_n
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAND_AMPLITUDE_AVERAGER_MACROS_SVH
`define SPECTRUM_BAND_AMPLITUDE_AVERAGER_MACROS_SVH

// checked only out of reset
`define SBAA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SBAA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sbaa_pkg.sv
// ----------------------------------------------------------------------------
// sbaa_pkg
// types and constants of the spectrum band amplitude averager
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbaa_pkg;

  localparam int MAX_GROUP = 1024;
  localparam int SAMPLE_W  = 16;
  localparam int GRP_W     = 11;
  localparam int SCALE_W   = 32;
  localparam int ACC_W     = 43;
  localparam int AMP_W     = 38;
  localparam int RAD_W     = 2 * AMP_W;
  localparam int REM_W     = AMP_W + 4;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_SCALE = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] bin_real;
    logic signed [SAMPLE_W-1:0] bin_imag;
    logic                       spectrum_end;
  } in_item_t;

  typedef struct packed {
    logic [AMP_W-1:0] amplitude;
    logic             group_valid;
    logic             row_end;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/sbaa_sqrt.sv
// ----------------------------------------------------------------------------
// sbaa_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbaa_sqrt
  import sbaa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [RAD_W-1:0] radicand,
  output logic                  done,
  output logic [AMP_W-1:0]      root
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [AMP_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = {{(REM_W-AMP_W-2){1'b0}}, root_r, 2'b01};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(AMP_W - 1);
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[AMP_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[AMP_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

FILE: rtl/spectrum_band_amplitude_averager.sv
// ----------------------------------------------------------------------------
// spectrum_band_amplitude_averager
// band-averaged amplitude spectrum: sums bin power over groups of bins and
// gives the square root of the scaled group power
// ----------------------------------------------------------------------------
// A bin that does not close a group passes through S_SQRE, S_SQIM and S_ACC
// before the next bin is taken: the squares of its real and imaginary parts
// share one 32x32 multiplier and are added in S_SQIM and S_ACC. A bin that
// closes a group then takes two more passes through the same multiplier for
// the 43x32 product of power and scale, then a one-bit-per-cycle square root
// over 38 root bits, then the result register. A spectrum end on a partial
// group drops its sum and gives a row-end item. The result register lets the
// next bin in while a result still waits.
`timescale 1ns / 1ps
`default_nettype none

`include "spectrum_band_amplitude_averager_macros.svh"

module spectrum_band_amplitude_averager
  import sbaa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQRE = 4'd1;
  localparam logic [3:0] S_SQIM = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_MLO  = 4'd4;
  localparam logic [3:0] S_MHI  = 4'd5;
  localparam logic [3:0] S_MSUM = 4'd6;
  localparam logic [3:0] S_ROOT = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [GRP_W-1:0]    group_size_r;
  logic [SCALE_W-1:0]  power_scale_r;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [GRP_W-1:0]    cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0] re_r, im_r;
  logic                last_r;
  logic [63:0]         prod_r, wide_r, prod_w;
  logic [31:0]         mul_a, mul_b;
  logic [AMP_W-1:0]    res_amp_r, res_amp_nxt;
  logic                res_gv_r, res_gv_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic [GRP_W-1:0]    grp_eff;
  logic [GRP_W-1:0]    cnt_inc;
  logic                in_acc;
  logic                out_free;
  logic                sqrt_start;
  logic                sqrt_done;
  logic [RAD_W-1:0]    radicand;
  logic [AMP_W-1:0]    sqrt_root;
  logic [SAMPLE_W-1:0] re_mag, im_mag;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // magnitude of a two's complement sample, most negative value wraps to itself
  assign re_mag = in_data.bin_real[SAMPLE_W-1] ? SAMPLE_W'(~in_data.bin_real + 1'b1)
                                               : SAMPLE_W'(in_data.bin_real);
  assign im_mag = in_data.bin_imag[SAMPLE_W-1] ? SAMPLE_W'(~in_data.bin_imag + 1'b1)
                                               : SAMPLE_W'(in_data.bin_imag);

  always_comb begin
    priority if (group_size_r == '0) begin
      grp_eff = GRP_W'(1);
    end else if (group_size_r > GRP_W'(MAX_GROUP)) begin
      grp_eff = GRP_W'(MAX_GROUP);
    end else begin
      grp_eff = group_size_r;
    end
  end

  assign cnt_inc = cnt_r + 1'b1;

  // shared multiplier
  always_comb begin
    unique case (state_r)
      S_SQRE: begin
        mul_a = {16'b0, re_r};
        mul_b = {16'b0, re_r};
      end
      S_SQIM: begin
        mul_a = {16'b0, im_r};
        mul_b = {16'b0, im_r};
      end
      S_MLO: begin
        mul_a = acc_r[31:0];
        mul_b = power_scale_r;
      end
      S_MHI: begin
        mul_a = {{(64-ACC_W){1'b0}}, acc_r[ACC_W-1:32]};
        mul_b = power_scale_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_w = 64'(mul_a) * 64'(mul_b);

  assign radicand = {1'b0, prod_r[ACC_W-1:0], 32'b0} + {{(RAD_W-64){1'b0}}, wide_r};
  assign sqrt_start = (state_r == S_MSUM);

  sbaa_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    res_amp_nxt   = res_amp_r;
    res_gv_nxt    = res_gv_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SQRE;
        end
      end
      S_SQRE: begin
        state_nxt = S_SQIM;
      end
      S_SQIM: begin
        acc_nxt   = acc_r + prod_r[ACC_W-1:0];
        state_nxt = S_ACC;
      end
      S_ACC: begin
        priority if (cnt_inc >= grp_eff) begin
          acc_nxt   = acc_r + prod_r[ACC_W-1:0];
          cnt_nxt   = '0;
          state_nxt = S_MLO;
        end else if (last_r) begin
          acc_nxt     = '0;
          cnt_nxt     = '0;
          res_amp_nxt = '0;
          res_gv_nxt  = 1'b0;
          state_nxt   = S_OUT;
        end else begin
          acc_nxt   = acc_r + prod_r[ACC_W-1:0];
          cnt_nxt   = cnt_inc;
          state_nxt = S_IDLE;
        end
      end
      S_MLO: begin
        state_nxt = S_MHI;
      end
      S_MHI: begin
        state_nxt = S_MSUM;
      end
      S_MSUM: begin
        acc_nxt   = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (sqrt_done) begin
          res_amp_nxt = sqrt_root;
          res_gv_nxt  = 1'b1;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.amplitude   = res_amp_r;
          out_data_nxt.group_valid = res_gv_r;
          out_data_nxt.row_end     = last_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      acc_r         <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      group_size_r  <= GRP_W'(1);
      power_scale_r <= '0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GROUP_SIZE:  group_size_r  <= cfg_data[GRP_W-1:0];
          REG_POWER_SCALE: power_scale_r <= cfg_data[SCALE_W-1:0];
        endcase
      end
    end
    if (in_acc) begin
      re_r   <= re_mag;
      im_r   <= im_mag;
      last_r <= in_data.spectrum_end;
    end
    prod_r     <= prod_w;
    if (state_r == S_MHI) begin
      wide_r <= prod_r;
    end
    res_amp_r  <= res_amp_nxt;
    res_gv_r   <= res_gv_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SBAA_ASSERT(a_accept_starts_work, in_acc |=> state_r == S_SQRE, "item accepted but work did not start")
  `SBAA_ASSERT(a_count_in_range, cnt_r < GRP_W'(MAX_GROUP), "group bin count out of range")
  `SBAA_ASSERT(a_root_only_waited, sqrt_done |-> state_r == S_ROOT, "square root finished while not awaited")
  `SBAA_ASSERT(a_invalid_is_row_end, out_valid && !out_data.group_valid |-> out_data.row_end && out_data.amplitude == '0, "invalid result without row end or with amplitude")
  `SBAA_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

`default_nettype wire

FILE: test/spectrum_band_amplitude_averager_tb.sv
// ----------------------------------------------------------------------------
// spectrum_band_amplitude_averager_tb
// self-checking bench: streams complex bins through the valid/stall port,
// predicts the band amplitude and row end that each accepted bin causes and
// compares every result item, field by field, with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spectrum_band_amplitude_averager_tb;
  import sbaa_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_BINS   = 48;
  localparam int PHASE_BINS    = 16;
  localparam logic [AMP_W-1:0] AMP_MAX = '1;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // band predictor state and register copies
  logic [GRP_W-1:0]   band_group = GRP_W'(1);
  logic [SCALE_W-1:0] band_scale = '0;
  logic [ACC_W-1:0]   band_power = '0;
  int unsigned        bins_seen  = 0;
  out_item_t          pending_bands[$];
  out_item_t          band_want;

  int unsigned mismatches   = 0;
  int unsigned idle_run     = 0;
  int unsigned rx_hold_left = 0;
  bit          rx_hold_req  = 1'b0;
  bit          quiet        = 1'b0;

  spectrum_band_amplitude_averager DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic predict_band(input in_item_t b);
    longint          re_sq, im_sq;
    int unsigned     eff;
    int              k;
    logic [95:0]     prod, sq;
    logic [47:0]     root, trial;
    out_item_t       r;
    re_sq = longint'($signed(b.bin_real)) * longint'($signed(b.bin_real));
    im_sq = longint'($signed(b.bin_imag)) * longint'($signed(b.bin_imag));
    eff = (band_group == 0) ? 1 : (band_group > MAX_GROUP) ? MAX_GROUP : band_group;
    band_power = band_power + ACC_W'(re_sq + im_sq);
    bins_seen++;
    if (bins_seen >= eff) begin
      prod = 96'(band_power) * 96'(band_scale);
      root = '0;
      for (k = 47; k >= 0; k--) begin
        trial = root | (48'd1 << k);
        sq = 96'(trial) * 96'(trial);
        if (sq <= prod) begin
          root = trial;
        end
      end
      r.amplitude   = (root > 48'(AMP_MAX)) ? AMP_MAX : root[AMP_W-1:0];
      r.group_valid = 1'b1;
      r.row_end     = b.spectrum_end;
      pending_bands.push_back(r);
      band_power = '0;
      bins_seen  = 0;
    end else if (b.spectrum_end) begin
      r = '0;
      r.row_end = 1'b1;
      pending_bands.push_back(r);
      band_power = '0;
      bins_seen  = 0;
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3: return SAMPLE_W'($urandom_range(0, 15)) - SAMPLE_W'(8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t bin_of(input logic [SAMPLE_W-1:0] re, im, input logic last);
    in_item_t b;
    b.bin_real     = re;
    b.bin_imag     = im;
    b.spectrum_end = last;
    return b;
  endfunction

  task automatic send_bin(input in_item_t b);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_band(b);
  endtask

  task automatic send_spectrum(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_bin(bin_of(rand_sample(), rand_sample(), i == n - 1));
    end
  endtask

  // block may still be summing a partial group after the last result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [GRP_W-1:0] grp, input logic [SCALE_W-1:0] scale);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_GROUP_SIZE;
    cfg_data  <= CFG_W'(grp);
    @(posedge clk);
    cfg_index <= REG_POWER_SCALE;
    cfg_data  <= scale;
    @(posedge clk);
    cfg_we <= 1'b0;
    band_group = grp;
    band_scale = scale;
  endtask

  task automatic check_field(input string name, input logic [AMP_W-1:0] want, got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bands.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none, actual amp %0d valid %0b end %0b",
                 $time, out_data.amplitude, out_data.group_valid, out_data.row_end);
      end else begin
        band_want = pending_bands.pop_front();
        check_field("amplitude", band_want.amplitude, out_data.amplitude);
        check_field("group_valid", band_want.group_valid, out_data.group_valid);
        check_field("row_end", band_want.row_end, out_data.row_end);
      end
    end
  end

  // receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left != 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("** spectrum_band_amplitude_averager: FAILED **");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  task automatic test_reset_defaults();
    send_bin(bin_of(16'h8000, 16'h7fff, 1'b0));
    send_bin(bin_of(rand_sample(), rand_sample(), 1'b1));
  endtask

  task automatic test_field_extremes();
    set_config(GRP_W'(1), '1);
    send_bin(bin_of(16'h8000, 16'h8000, 1'b0));
    send_bin(bin_of(16'h7fff, 16'h7fff, 1'b0));
    send_bin(bin_of(16'h0000, 16'h0000, 1'b0));
    send_bin(bin_of(16'hffff, 16'h0001, 1'b0));
    send_bin(bin_of(16'h8000, 16'h7fff, 1'b1));
  endtask

  // partial group dropped at row end, then a group closed by the last bin
  task automatic test_partial_groups();
    set_config(GRP_W'(3), $urandom);
    for (int i = 0; i < 8; i++) begin
      send_bin(bin_of(rand_sample(), rand_sample(), i == 4 || i == 7));
    end
  endtask

  task automatic test_zero_group();
    set_config('0, $urandom);
    send_spectrum(2);
  endtask

  // group size lowered and raised while a group is part summed
  task automatic test_regroup_midway();
    set_config(GRP_W'(8), $urandom);
    for (int i = 0; i < 5; i++) begin
      send_bin(bin_of(rand_sample(), rand_sample(), 1'b0));
    end
    set_config(GRP_W'(3), $urandom);
    send_bin(bin_of(rand_sample(), rand_sample(), 1'b0));
    set_config(GRP_W'(2), $urandom);
    send_bin(bin_of(rand_sample(), rand_sample(), 1'b0));
    set_config(GRP_W'(5), $urandom);
    send_spectrum(4);
  endtask

  task automatic test_backpressure();
    set_config(GRP_W'(1), $urandom);
    rx_hold_req = 1'b1;
    send_spectrum(16);
    wait_idle();
    send_spectrum(4);
  endtask

  // oversized group size clamps, full-scale bins give the largest amplitude,
  // streamed without idling
  task automatic test_largest_group();
    set_config('1, '1);
    quiet = 1'b1;
    for (int i = 0; i < MAX_GROUP; i++) begin
      send_bin(bin_of(16'h8000, 16'h8000, i == MAX_GROUP - 1));
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_bands();
    int unsigned          sent, phase, phase_bins, eff, len;
    logic [GRP_W-1:0]     grp;
    logic [SCALE_W-1:0]   scale;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BINS) begin
      case ($urandom_range(9))
        0: grp = '0;
        1: grp = GRP_W'(1);
        2: grp = GRP_W'($urandom_range(17, 24));
        default: grp = GRP_W'($urandom_range(2, 16));
      endcase
      case ($urandom_range(5))
        0: scale = '0;
        1: scale = '1;
        2: scale = SCALE_W'($urandom_range(1, 255));
        default: scale = $urandom;
      endcase
      set_config(grp, scale);
      quiet = (phase == 2);
      eff = (grp == 0) ? 1 : grp;
      phase_bins = 0;
      while (phase_bins < PHASE_BINS) begin
        len = $urandom_range(1, 3 * eff + 2);
        send_spectrum(len);
        phase_bins += len;
      end
      quiet = 1'b0;
      sent += phase_bins;
      phase++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_partial_groups();
    test_zero_group();
    test_regroup_midway();
    test_backpressure();
    test_largest_group();
    test_random_bands();
    wait_idle();
    if (mismatches == 0 && pending_bands.size() == 0) begin
      $display("** spectrum_band_amplitude_averager: PASSED **");
    end else begin
      $display("** spectrum_band_amplitude_averager: FAILED **");
    end
    $finish;
  end

endmodule
